>>> src/tgc_pkg.sv
// ----------------------------------------------------------------------------
// tgc_pkg: shared types and constants for the touch gesture classifier
// Word layouts, register indexes, gesture codes and controller/datapath links.
// ----------------------------------------------------------------------------
package tgc_pkg;

   localparam int COORD_BITS     = 16;   // coordinate bits kept from a sample
   localparam int POS_BITS       = 16;   // coordinate field width on the port
   localparam int EXT_BITS       = 16;   // panel extent width
   localparam int TIME_BITS      = 32;
   localparam int DIST_BITS      = 33;   // exact dx^2 + dy^2
   localparam int SQ_BITS        = 2 * COORD_BITS;
   localparam int LIM_BITS       = 16;
   localparam int QUOT_BITS      = 17;   // Q1.16 result
   localparam int CNT_BITS       = 5;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [QUOT_BITS-1:0] Q_ONE = QUOT_BITS'(65536);

   // gesture codes
   localparam logic [1:0] GEST_NONE  = 2'd0;
   localparam logic [1:0] GEST_TAP   = 2'd1;
   localparam logic [1:0] GEST_LONG  = 2'd2;
   localparam logic [1:0] GEST_SWIPE = 2'd3;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SWIPE_MIN  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SLOP       = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TAP_MAX    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LONG_PRESS = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WIDTH      = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HEIGHT     = 3'd5;

   // register reset values
   localparam logic [LIM_BITS-1:0]  RST_SWIPE_MIN  = 16'd40;
   localparam logic [LIM_BITS-1:0]  RST_SLOP       = 16'd10;
   localparam logic [TIME_BITS-1:0] RST_TAP_MAX    = 32'd300;
   localparam logic [TIME_BITS-1:0] RST_LONG_PRESS = 32'd600;
   localparam logic [EXT_BITS-1:0]  RST_WIDTH      = 16'd600;
   localparam logic [EXT_BITS-1:0]  RST_HEIGHT     = 16'd800;

   typedef struct packed {
      logic                 mode;
      logic [POS_BITS-1:0]  pos_x;
      logic [POS_BITS-1:0]  pos_y;
      logic                 contact;
      logic [TIME_BITS-1:0] now_time;
   } tgc_req_type;

   typedef struct packed {
      logic [1:0]           gesture;
      logic [QUOT_BITS-1:0] begin_x_norm;
      logic [QUOT_BITS-1:0] begin_y_norm;
      logic [QUOT_BITS-1:0] end_x_norm;
      logic [QUOT_BITS-1:0] end_y_norm;
      logic [TIME_BITS-1:0] held_time;
   } tgc_rsp_type;

   typedef struct packed {
      logic       capture;      // latch the input word
      logic       set_origin;   // contact start: origin point and time
      logic       set_latest;   // current point from the word
      logic       square;       // register squares and held time
      logic       div_start;    // launch both normalizers
      logic       div_origin;   // normalize origin instead of latest
      logic       latch_begin;  // normalizer results to begin and end
      logic       latch_end;    // normalizer results to end only
      logic       load_out;     // fill the output register
      logic [1:0] kind;
   } tgc_cmd_type;

   typedef struct packed {
      logic tick;
      logic contact;
      logic far_swipe;
      logic far_slop;
      logic tap_ok;
      logic hold_ok;
      logic div_busy;
   } tgc_status_type;

endpackage

>>> src/tgc_div.sv
// ----------------------------------------------------------------------------
// tgc_div: Q1.16 coordinate normalizer
// Restoring divider, one quotient bit per cycle: (v*2^17 + d) / (2d), d = ext-1.
// ----------------------------------------------------------------------------
module tgc_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [tgc_pkg::COORD_BITS-1:0]      value,
   input  logic [tgc_pkg::EXT_BITS-1:0]        extent,
   output logic                                busy,
   output logic [tgc_pkg::QUOT_BITS-1:0]       quot
);

   logic                              busy_ff, busy_in;
   logic [tgc_pkg::CNT_BITS-1:0]      cnt_ff, cnt_in;
   logic [tgc_pkg::QUOT_BITS:0]       rem_ff, rem_in;
   logic [tgc_pkg::QUOT_BITS-1:0]     div_ff, div_in;
   logic [tgc_pkg::QUOT_BITS-1:0]     bits_ff, bits_in;
   logic [tgc_pkg::QUOT_BITS-1:0]     quot_ff, quot_in;
   logic [tgc_pkg::EXT_BITS-1:0]      dm1;
   logic [tgc_pkg::EXT_BITS-1:0]      v_ext;
   logic [tgc_pkg::QUOT_BITS:0]       shifted;
   logic                              fits;

   assign dm1     = extent - tgc_pkg::EXT_BITS'(1);
   assign v_ext   = tgc_pkg::EXT_BITS'(value);
   assign shifted = {rem_ff[tgc_pkg::QUOT_BITS-1:0], bits_ff[tgc_pkg::QUOT_BITS-1]};
   assign fits    = shifted >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      bits_in = bits_ff;
      quot_in = quot_ff;
      if (start) begin
         cnt_in  = '0;
         rem_in  = (tgc_pkg::QUOT_BITS + 1)'(v_ext);
         div_in  = {dm1, 1'b0};
         bits_in = tgc_pkg::QUOT_BITS'(dm1);
         if (extent <= tgc_pkg::EXT_BITS'(1)) begin
            quot_in = '0;
            busy_in = 1'b0;
         end else if (v_ext >= dm1) begin
            // at or past the far edge: saturate at 1.0
            quot_in = tgc_pkg::Q_ONE;
            busy_in = 1'b0;
         end else begin
            quot_in = '0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         rem_in  = fits ? shifted - {1'b0, div_ff} : shifted;
         quot_in = {quot_ff[tgc_pkg::QUOT_BITS-2:0], fits};
         bits_in = {bits_ff[tgc_pkg::QUOT_BITS-2:0], 1'b0};
         cnt_in  = cnt_ff + tgc_pkg::CNT_BITS'(1);
         if (cnt_ff == tgc_pkg::CNT_BITS'(tgc_pkg::QUOT_BITS - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      cnt_ff  <= cnt_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      bits_ff <= bits_in;
      quot_ff <= quot_in;
   end

   assign busy = busy_ff;
   assign quot = quot_ff;

endmodule

>>> src/tgc_datapath.sv
// ----------------------------------------------------------------------------
// tgc_datapath: classifier datapath
// Registers, contact geometry, distance squares, normalizers and result word.
// ----------------------------------------------------------------------------
module tgc_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  tgc_pkg::tgc_req_type                   req_word,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [tgc_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [tgc_pkg::CSR_DATA_BITS-1:0]      csr_data,
   input  tgc_pkg::tgc_cmd_type                   cmd,
   output tgc_pkg::tgc_status_type                status,
   output tgc_pkg::tgc_rsp_type                   rsp_word
);

   localparam int CB = tgc_pkg::COORD_BITS;
   localparam int QB = tgc_pkg::QUOT_BITS;

   // registers
   logic [tgc_pkg::LIM_BITS-1:0]  swipe_min_ff, swipe_min_in;
   logic [tgc_pkg::LIM_BITS-1:0]  slop_ff, slop_in;
   logic [tgc_pkg::TIME_BITS-1:0] tap_max_ff, tap_max_in;
   logic [tgc_pkg::TIME_BITS-1:0] long_press_ff, long_press_in;
   logic [tgc_pkg::EXT_BITS-1:0]  width_ff, width_in;
   logic [tgc_pkg::EXT_BITS-1:0]  height_ff, height_in;

   tgc_pkg::tgc_req_type          cap_ff, cap_in;
   logic [CB-1:0]                 origin_x_ff, origin_x_in, origin_y_ff, origin_y_in;
   logic [CB-1:0]                 latest_x_ff, latest_x_in, latest_y_ff, latest_y_in;
   logic [tgc_pkg::TIME_BITS-1:0] origin_time_ff, origin_time_in;

   logic [tgc_pkg::SQ_BITS-1:0]   dx2_ff, dx2_in, dy2_ff, dy2_in;
   logic [2*tgc_pkg::LIM_BITS-1:0] swipe2_ff, swipe2_in, slop2_ff, slop2_in;
   logic [tgc_pkg::TIME_BITS-1:0] held_ff, held_in;

   logic [QB-1:0] bx_ff, bx_in, by_ff, by_in, ex_ff, ex_in, ey_ff, ey_in;
   tgc_pkg::tgc_rsp_type          rsp_ff, rsp_in;

   logic [CB-1:0]                 dx, dy, div_vx, div_vy;
   logic [tgc_pkg::DIST_BITS-1:0] dist2;
   logic                          busy_x, busy_y;
   logic [QB-1:0]                 qx, qy;

   // ---- configuration ----
   always_comb begin
      swipe_min_in  = swipe_min_ff;
      slop_in       = slop_ff;
      tap_max_in    = tap_max_ff;
      long_press_in = long_press_ff;
      width_in      = width_ff;
      height_in     = height_ff;
      if (csr_valid) begin
         case (csr_index)
            tgc_pkg::CSR_SWIPE_MIN:  swipe_min_in  = csr_data[tgc_pkg::LIM_BITS-1:0];
            tgc_pkg::CSR_SLOP:       slop_in       = csr_data[tgc_pkg::LIM_BITS-1:0];
            tgc_pkg::CSR_TAP_MAX:    tap_max_in    = csr_data[tgc_pkg::TIME_BITS-1:0];
            tgc_pkg::CSR_LONG_PRESS: long_press_in = csr_data[tgc_pkg::TIME_BITS-1:0];
            tgc_pkg::CSR_WIDTH:      width_in      = csr_data[tgc_pkg::EXT_BITS-1:0];
            tgc_pkg::CSR_HEIGHT:     height_in     = csr_data[tgc_pkg::EXT_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // ---- contact geometry ----
   always_comb begin
      cap_in         = cmd.capture    ? req_word : cap_ff;
      origin_x_in    = cmd.set_origin ? cap_ff.pos_x[CB-1:0] : origin_x_ff;
      origin_y_in    = cmd.set_origin ? cap_ff.pos_y[CB-1:0] : origin_y_ff;
      origin_time_in = cmd.set_origin ? cap_ff.now_time : origin_time_ff;
      latest_x_in    = cmd.set_latest ? cap_ff.pos_x[CB-1:0] : latest_x_ff;
      latest_y_in    = cmd.set_latest ? cap_ff.pos_y[CB-1:0] : latest_y_ff;
   end

   assign dx = (origin_x_ff > latest_x_ff) ? origin_x_ff - latest_x_ff
                                           : latest_x_ff - origin_x_ff;
   assign dy = (origin_y_ff > latest_y_ff) ? origin_y_ff - latest_y_ff
                                           : latest_y_ff - origin_y_ff;

   // squares are registered before the sum and compare
   always_comb begin
      dx2_in    = dx2_ff;
      dy2_in    = dy2_ff;
      swipe2_in = swipe2_ff;
      slop2_in  = slop2_ff;
      held_in   = held_ff;
      if (cmd.square) begin
         dx2_in    = dx * dx;
         dy2_in    = dy * dy;
         swipe2_in = swipe_min_ff * swipe_min_ff;
         slop2_in  = slop_ff * slop_ff;
         held_in   = cap_ff.now_time - origin_time_ff;
      end
   end

   assign dist2 = tgc_pkg::DIST_BITS'(dx2_ff) + tgc_pkg::DIST_BITS'(dy2_ff);

   always_comb begin
      status.tick      = cap_ff.mode;
      status.contact   = cap_ff.contact;
      status.far_swipe = dist2 > tgc_pkg::DIST_BITS'(swipe2_ff);
      status.far_slop  = dist2 > tgc_pkg::DIST_BITS'(slop2_ff);
      status.tap_ok    = held_ff <= tap_max_ff;
      status.hold_ok   = held_ff >= long_press_ff;
      status.div_busy  = busy_x | busy_y;
   end

   // ---- normalizers, one per axis ----
   assign div_vx = cmd.div_origin ? origin_x_ff : latest_x_ff;
   assign div_vy = cmd.div_origin ? origin_y_ff : latest_y_ff;

   tgc_div u_div_x (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.div_start),
      .value  (div_vx),
      .extent (width_ff),
      .busy   (busy_x),
      .quot   (qx)
   );

   tgc_div u_div_y (
      .clock  (clock),
      .reset  (reset),
      .start  (cmd.div_start),
      .value  (div_vy),
      .extent (height_ff),
      .busy   (busy_y),
      .quot   (qy)
   );

   always_comb begin
      bx_in = cmd.latch_begin ? qx : bx_ff;
      by_in = cmd.latch_begin ? qy : by_ff;
      ex_in = (cmd.latch_begin || cmd.latch_end) ? qx : ex_ff;
      ey_in = (cmd.latch_begin || cmd.latch_end) ? qy : ey_ff;
   end

   // ---- result word ----
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.load_out) begin
         if (cmd.kind == tgc_pkg::GEST_NONE) begin
            rsp_in = '0;
         end else begin
            rsp_in.gesture      = cmd.kind;
            rsp_in.begin_x_norm = bx_ff;
            rsp_in.begin_y_norm = by_ff;
            rsp_in.end_x_norm   = ex_ff;
            rsp_in.end_y_norm   = ey_ff;
            rsp_in.held_time    = held_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         swipe_min_ff  <= tgc_pkg::RST_SWIPE_MIN;
         slop_ff       <= tgc_pkg::RST_SLOP;
         tap_max_ff    <= tgc_pkg::RST_TAP_MAX;
         long_press_ff <= tgc_pkg::RST_LONG_PRESS;
         width_ff      <= tgc_pkg::RST_WIDTH;
         height_ff     <= tgc_pkg::RST_HEIGHT;
      end else begin
         swipe_min_ff  <= swipe_min_in;
         slop_ff       <= slop_in;
         tap_max_ff    <= tap_max_in;
         long_press_ff <= long_press_in;
         width_ff      <= width_in;
         height_ff     <= height_in;
      end
      cap_ff         <= cap_in;
      origin_x_ff    <= origin_x_in;
      origin_y_ff    <= origin_y_in;
      origin_time_ff <= origin_time_in;
      latest_x_ff    <= latest_x_in;
      latest_y_ff    <= latest_y_in;
      dx2_ff         <= dx2_in;
      dy2_ff         <= dy2_in;
      swipe2_ff      <= swipe2_in;
      slop2_ff       <= slop2_in;
      held_ff        <= held_in;
      bx_ff          <= bx_in;
      by_ff          <= by_in;
      ex_ff          <= ex_in;
      ey_ff          <= ey_in;
      rsp_ff         <= rsp_in;
   end

   assign rsp_word = rsp_ff;

endmodule

>>> src/tgc_ctrl.sv
// ----------------------------------------------------------------------------
// tgc_ctrl: classifier controller
// Contact flags, per-word sequencing, gesture decision and output handshake.
// ----------------------------------------------------------------------------
module tgc_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  tgc_pkg::tgc_status_type   status,
   output tgc_pkg::tgc_cmd_type      cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_APPLY, ST_SQUARE, ST_DECIDE, ST_BEGIN, ST_BEGIN_WAIT,
      ST_END, ST_END_WAIT, ST_DONE
   } state_type;

   typedef enum logic {PLAN_HOLD, PLAN_LIFT} plan_type;

   state_type  state_ff, state_in;
   plan_type   plan_ff, plan_in;
   logic [1:0] kind_ff, kind_in;
   logic       touching_ff, touching_in;
   logic       swallow_ff, swallow_in;
   logic       hold_rep_ff, hold_rep_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      plan_in      = plan_ff;
      kind_in      = kind_ff;
      touching_in  = touching_ff;
      swallow_in   = swallow_ff;
      hold_rep_in  = hold_rep_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      cmd.kind     = kind_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_APPLY;
            end
         end
         ST_APPLY: begin
            kind_in  = tgc_pkg::GEST_NONE;
            state_in = ST_SQUARE;
            if (status.tick) begin
               plan_in = PLAN_HOLD;
            end else if (status.contact && !touching_ff) begin
               // contact start
               cmd.set_origin = 1'b1;
               cmd.set_latest = 1'b1;
               touching_in    = 1'b1;
               swallow_in     = 1'b0;
               hold_rep_in    = 1'b0;
               state_in       = ST_DONE;
            end else if (status.contact) begin
               cmd.set_latest = 1'b1;
               plan_in        = PLAN_HOLD;
            end else if (!touching_ff) begin
               state_in = ST_DONE;
            end else begin
               cmd.set_latest = 1'b1;
               touching_in    = 1'b0;
               plan_in        = PLAN_LIFT;
               if (swallow_ff) begin
                  swallow_in = 1'b0;
                  state_in   = ST_DONE;
               end
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_DECIDE;
         end
         ST_DECIDE: begin
            kind_in = tgc_pkg::GEST_NONE;
            case (plan_ff)
               PLAN_HOLD: begin
                  if (touching_ff && !swallow_ff && !hold_rep_ff &&
                      status.hold_ok && !status.far_slop) begin
                     kind_in     = tgc_pkg::GEST_LONG;
                     hold_rep_in = 1'b1;
                     swallow_in  = 1'b1;
                  end
               end
               PLAN_LIFT: begin
                  if (status.far_swipe) begin
                     kind_in = tgc_pkg::GEST_SWIPE;
                  end else if (status.tap_ok && !status.far_slop) begin
                     kind_in = tgc_pkg::GEST_TAP;
                  end
               end
               default: ;
            endcase
            state_in = (kind_in == tgc_pkg::GEST_NONE) ? ST_DONE : ST_BEGIN;
         end
         ST_BEGIN: begin
            cmd.div_start  = 1'b1;
            cmd.div_origin = (kind_ff == tgc_pkg::GEST_SWIPE);
            state_in       = ST_BEGIN_WAIT;
         end
         ST_BEGIN_WAIT: begin
            if (!status.div_busy) begin
               cmd.latch_begin = 1'b1;
               state_in = (kind_ff == tgc_pkg::GEST_SWIPE) ? ST_END : ST_DONE;
            end
         end
         ST_END: begin
            cmd.div_start = 1'b1;
            state_in      = ST_END_WAIT;
         end
         ST_END_WAIT: begin
            if (!status.div_busy) begin
               cmd.latch_end = 1'b1;
               state_in      = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         touching_ff  <= 1'b0;
         swallow_ff   <= 1'b0;
         hold_rep_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         plan_ff      <= PLAN_HOLD;
         kind_ff      <= tgc_pkg::GEST_NONE;
      end else begin
         state_ff     <= state_in;
         touching_ff  <= touching_in;
         swallow_ff   <= swallow_in;
         hold_rep_ff  <= hold_rep_in;
         rsp_valid_ff <= rsp_valid_in;
         plan_ff      <= plan_in;
         kind_ff      <= kind_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> src/touch_gesture_classifier.sv
// ----------------------------------------------------------------------------
// touch_gesture_classifier: tap, long press and swipe detection
// Contact-start words, idle lifts and swallowed lifts go straight to done; other no-gesture
//   words pass square and decide; tap/long press run one Q1.16 normalize, swipe runs two.
// Throughput: one word at a time; the next word is taken once the current one
//   reaches the output register.
// Reset (synchronous, active high): registers to defaults, no contact, no word.
// ----------------------------------------------------------------------------
// Every accepted word yields exactly one rsp word. The controller keeps the
// contact flags (touching, swallow rest of contact, long press reported) and
// walks each word through:
//   apply   - capture point into origin/latest per the contact transition
//   square  - dx^2, dy^2, limit^2 and held time into registers
//   decide  - exact 33-bit distance compares and time checks pick the gesture
//   begin   - normalize begin point (origin for swipe, current otherwise)
//   end     - swipe only: normalize current point
//   done    - hand the word to the output register when it is free
// Words that cannot give a gesture skip straight to done with a zero word.
// The output register lets a new req word in while the last rsp word waits.
// Config writes are always accepted (csr_ready high); unknown indexes are
// ignored. Write config only while no word is in flight.
// ----------------------------------------------------------------------------
module touch_gesture_classifier (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  tgc_pkg::tgc_req_type                req_word,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output tgc_pkg::tgc_rsp_type                rsp_word,
   // register write port
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [tgc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [tgc_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   tgc_pkg::tgc_cmd_type    cmd;
   tgc_pkg::tgc_status_type status;

   tgc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   tgc_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_word  (req_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_word  (rsp_word)
   );

endmodule

>>> src/tgc_checker.sv
// ----------------------------------------------------------------------------
// tgc_checker: port-level checks for the touch gesture classifier
// Result word shape, handshake hold and one-word-at-a-time intake.
// ----------------------------------------------------------------------------
module tgc_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input tgc_pkg::tgc_rsp_type  rsp_word
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("rsp word changed while stalled");

   // no gesture means an all-zero word
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word.gesture == tgc_pkg::GEST_NONE |->
         rsp_word.begin_x_norm == '0 && rsp_word.begin_y_norm == '0 &&
         rsp_word.end_x_norm == '0 && rsp_word.end_y_norm == '0 &&
         rsp_word.held_time == '0)
      else $error("non-zero fields without a gesture");

   // tap and long press report the current point for both ends
   a_point_same: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.gesture == tgc_pkg::GEST_TAP ||
                    rsp_word.gesture == tgc_pkg::GEST_LONG) |->
         rsp_word.begin_x_norm == rsp_word.end_x_norm &&
         rsp_word.begin_y_norm == rsp_word.end_y_norm)
      else $error("tap or long press with differing points");

   // normalized values never pass 1.0
   a_q_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_word.begin_x_norm <= tgc_pkg::Q_ONE &&
                    rsp_word.begin_y_norm <= tgc_pkg::Q_ONE &&
                    rsp_word.end_x_norm <= tgc_pkg::Q_ONE &&
                    rsp_word.end_y_norm <= tgc_pkg::Q_ONE)
      else $error("normalized coordinate above 1.0");

   // one word in flight: intake closes right after an accept
   a_one_word: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word taken while one is in flight");

endmodule

bind touch_gesture_classifier tgc_checker u_tgc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
